>>> sv/affine_matrix_inverse_macros.svh
// Assertion macros used by the checker file of the affine inverse block.
`ifndef AFFINE_MATRIX_INVERSE_MACROS_SVH
`define AFFINE_MATRIX_INVERSE_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define AMINV_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define AMINV_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/aminv_pkg.sv
// Shared constants, types and the multiply-accumulate program of the affine inverse block.
package aminv_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;
   localparam int NCOEF      = 12;
   localparam int IDX_W      = 4;
   localparam int NCOF       = 9;
   // cofactor, determinant/accumulator, shifted numerator, quotient widths
   localparam int CW    = 2 * DATA_WIDTH + 1;
   localparam int XW    = 3 * DATA_WIDTH + 3;
   localparam int NW    = XW + FRAC_BITS;
   localparam int QW    = NW + 1;
   localparam int CNT_W = $clog2(QW);
   localparam int OP_W  = 5;

   localparam logic [31:0] THRESH_RESET = 32'd2814750;
   localparam logic [OP_W-1:0] OP_DET_LAST = OP_W'(20);
   localparam logic [IDX_W-1:0] IDX_LIN_LAST = IDX_W'(8);
   localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(NCOEF - 1);

   typedef enum logic [1:0] {
      DST_NONE,
      DST_COF,
      DST_DET
   } dst_type;

   typedef struct packed {
      logic             a_cof;   // multiplicand from cofactor file, else entry store
      logic [IDX_W-1:0] a_idx;
      logic [IDX_W-1:0] b_idx;
      logic [IDX_W-1:0] d_idx;
      logic             clear;
      logic             negate;
      dst_type          dst;
   } mop_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_RDA,
      ST_RDB,
      ST_LDB,
      ST_MUL,
      ST_STORE,
      ST_CHECK,
      ST_SING,
      ST_DIVLD,
      ST_DIV,
      ST_DIVEND,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic             ram_we;
      logic [IDX_W-1:0] ram_raddr;
      logic [IDX_W-1:0] cof_addr;
      mop_type          mop;
      logic             load_a;
      logic             load_b;
      logic             mul_step;
      logic             mul_last;
      logic             store;
      logic             div_load;
      logic             div_tr;
      logic             div_step;
      logic             out_load;
      logic             sing_load;
      logic [IDX_W-1:0] out_index;
      logic             out_last;
   } cmd_type;

   typedef struct packed {
      logic singular;
   } status_type;

   // Program step n: 0-17 cofactor products, 18-20 determinant, 21-29 translation sums.
   // Entry a[r][c] lives at 3*c + r; cofactor adj[i][j] lives in slot 3*j + i.
   function automatic mop_type mop_of(input logic [OP_W-1:0] op);
      int n, s, i, j, r, c;
      mop_type m;
      n = int'(op);
      m = '0;
      if (n < 18) begin
         s = n / 2;
         i = s % 3;
         j = s / 3;
         if (n % 2 == 0) begin
            m.a_idx = IDX_W'(3 * ((i + 1) % 3) + (j + 1) % 3);
            m.b_idx = IDX_W'(3 * ((i + 2) % 3) + (j + 2) % 3);
            m.clear = 1'b1;
         end else begin
            m.a_idx  = IDX_W'(3 * ((i + 2) % 3) + (j + 1) % 3);
            m.b_idx  = IDX_W'(3 * ((i + 1) % 3) + (j + 2) % 3);
            m.negate = 1'b1;
            m.dst    = DST_COF;
            m.d_idx  = IDX_W'(s);
         end
      end else if (n < 21) begin
         i = n - 18;
         m.a_cof = 1'b1;
         m.a_idx = IDX_W'(i);
         m.b_idx = IDX_W'(3 * i);
         m.clear = (i == 0);
         m.dst   = (i == 2) ? DST_DET : DST_NONE;
      end else begin
         r = (n - 21) / 3;
         c = (n - 21) % 3;
         m.a_cof  = 1'b1;
         m.a_idx  = IDX_W'(3 * c + r);
         m.b_idx  = IDX_W'(9 + c);
         m.clear  = (c == 0);
         m.negate = 1'b1;
      end
      return m;
   endfunction

endpackage

>>> sv/affine_matrix_inverse.sv
// Affine 3x4 matrix inverse, Q16.16. Entries are taken one per beat, one per cycle while loading, in any
// order of index 0-11 (12-15 are dropped); the beat that brings the count to twelve starts a run and
// the input stays stalled until the run's last result is taken. A run holds 21 multiply-accumulate
// steps for the cofactors and determinant on a bit-serial multiplier, then per result one restoring
// division (one quotient bit per cycle) plus load, format and handshake steps, and for each translation
// result three further multiply-accumulate steps. A singular matrix gives one result with singular and
// last set. The threshold register is written through csr_we/csr_wdata and resets to 2814750 (|det| in
// Q16.48).
module affine_matrix_inverse import aminv_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [31:0]                  csr_wdata,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_coef_value,
   input  logic [IDX_W-1:0]             req_coef_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_value,
   output logic [IDX_W-1:0]             rsp_inv_index,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   output logic                         rsp_last
);

   cmd_type    cmd;
   status_type status;

   aminv_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coef_index(req_coef_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   aminv_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_coef_value(req_coef_value),
      .req_coef_index(req_coef_index),
      .cmd           (cmd),
      .status        (status),
      .rsp_inv_value (rsp_inv_value),
      .rsp_inv_index (rsp_inv_index),
      .rsp_singular  (rsp_singular),
      .rsp_saturated (rsp_saturated),
      .rsp_last      (rsp_last)
   );

endmodule

>>> sv/aminv_ram.sv
// Generic single-port-write, registered-read RAM.
module aminv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 12,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/aminv_ctrl.sv
// Sequencer: entry loading, multiply-accumulate program, division and result handshake.
module aminv_ctrl import aminv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [IDX_W-1:0] req_coef_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  status_type       status,
   output cmd_type          cmd
);

   state_type        state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] loaded_ff, loaded_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             sing_ff, sing_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         op_ff     <= '0;
         k_ff      <= '0;
         loaded_ff <= '0;
         cnt_ff    <= '0;
         sing_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         k_ff      <= k_in;
         loaded_ff <= loaded_in;
         cnt_ff    <= cnt_in;
         sing_ff   <= sing_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      k_in      = k_ff;
      loaded_in = loaded_ff;
      cnt_in    = cnt_ff;
      sing_in   = sing_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.mop   = mop_of(op_ff);
      cmd.out_index = k_ff;
      cmd.out_last  = (k_ff == IDX_LAST);
      case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid && req_coef_index < IDX_W'(NCOEF)) begin
               cmd.ram_we = 1'b1;
               if (loaded_ff == IDX_LAST) begin
                  loaded_in = '0;
                  op_in     = '0;
                  sing_in   = 1'b0;
                  state_in  = ST_RDA;
               end else begin
                  loaded_in = loaded_ff + IDX_W'(1);
               end
            end
         end
         ST_RDA: begin
            cmd.ram_raddr = cmd.mop.a_idx;
            cmd.cof_addr  = cmd.mop.a_idx;
            state_in      = ST_RDB;
         end
         ST_RDB: begin
            cmd.ram_raddr = cmd.mop.b_idx;
            cmd.cof_addr  = cmd.mop.a_idx;
            cmd.load_a    = 1'b1;
            state_in      = ST_LDB;
         end
         ST_LDB: begin
            cmd.load_b = 1'b1;
            cnt_in     = '0;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = (cnt_ff == CNT_W'(DATA_WIDTH - 1));
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cmd.mul_last) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            op_in     = op_ff + OP_W'(1);
            if (op_ff == OP_DET_LAST) begin
               state_in = ST_CHECK;
            end else if (op_ff > OP_DET_LAST && cmd.mop.b_idx == IDX_LAST) begin
               // third term of a translation sum: divide it now
               state_in = ST_DIVLD;
            end else begin
               state_in = ST_RDA;
            end
         end
         ST_CHECK: begin
            k_in = '0;
            if (status.singular) begin
               state_in = ST_SING;
            end else begin
               state_in = ST_DIVLD;
            end
         end
         ST_SING: begin
            cmd.sing_load = 1'b1;
            sing_in       = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_DIVLD: begin
            cmd.div_load = 1'b1;
            cmd.cof_addr = k_ff;
            cmd.div_tr   = (k_ff > IDX_LIN_LAST);
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(QW - 1)) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            cmd.out_load = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (sing_ff || k_ff == IDX_LAST) begin
                  state_in = ST_LOAD;
               end else begin
                  k_in = k_ff + IDX_W'(1);
                  if (k_ff >= IDX_LIN_LAST) begin
                     state_in = ST_RDA;
                  end else begin
                     state_in = ST_DIVLD;
                  end
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

>>> sv/aminv_dp.sv
// Datapath: entry RAM, bit-serial multiply-accumulate, cofactor file, restoring divider.
module aminv_dp import aminv_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [31:0]                  csr_wdata,
   input  logic signed [DATA_WIDTH-1:0] req_coef_value,
   input  logic [IDX_W-1:0]             req_coef_index,
   input  cmd_type                      cmd,
   output status_type                   status,
   output logic signed [DATA_WIDTH-1:0] rsp_inv_value,
   output logic [IDX_W-1:0]             rsp_inv_index,
   output logic                         rsp_singular,
   output logic                         rsp_saturated,
   output logic                         rsp_last
);

   logic [31:0]           thr_ff;
   logic [DATA_WIDTH-1:0] ram_rdata;
   logic [CW-1:0]         cof_ff [0:NCOF-1];
   logic [XW-1:0]         det_ff, acc_ff, mcand_ff, dp_ff, rem_ff;
   logic [DATA_WIDTH-1:0] mplier_ff;
   logic [QW-1:0]         np_ff, q_ff;
   logic                  neg_ff;
   logic [DATA_WIDTH-1:0] val_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic                  sing_ff, sat_ff, last_ff;

   logic [CW-1:0]         cof_rd, cof_mag;
   logic [XW-1:0]         det_mag, acc_mag, addend;
   logic [NW-1:0]         num_shift;
   logic                  num_neg;
   logic [XW:0]           trial;
   logic                  ge;
   logic [QW-1:0]         half, lim;
   logic                  sat;
   logic [DATA_WIDTH-1:0] mag_lo, val_sgn;

   aminv_ram #(
      .WIDTH(DATA_WIDTH),
      .DEPTH(NCOEF)
   ) u_ram (
      .clock(clock),
      .we   (cmd.ram_we),
      .waddr(req_coef_index),
      .wdata(req_coef_value),
      .raddr(cmd.ram_raddr),
      .rdata(ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESH_RESET;
      end else if (csr_we) begin
         thr_ff <= csr_wdata;
      end
   end

   assign cof_rd  = cof_ff[cmd.cof_addr];
   assign cof_mag = cof_rd[CW-1] ? (~cof_rd + CW'(1)) : cof_rd;
   assign det_mag = det_ff[XW-1] ? (~det_ff + XW'(1)) : det_ff;
   assign acc_mag = acc_ff[XW-1] ? (~acc_ff + XW'(1)) : acc_ff;

   assign status.singular = (det_ff == '0) || (det_mag < XW'(thr_ff));

   // top multiplier bit carries negative weight
   assign addend = (cmd.mop.negate ^ cmd.mul_last) ? (~mcand_ff + XW'(1)) : mcand_ff;

   assign num_neg   = cmd.div_tr ? acc_ff[XW-1] : cof_rd[CW-1];
   assign num_shift = cmd.div_tr ? (NW'(acc_mag) << FRAC_BITS)
                                 : (NW'(cof_mag) << (2 * FRAC_BITS));

   assign trial = {rem_ff, np_ff[QW-1]};
   assign ge    = (trial >= {1'b0, dp_ff});

   assign half    = QW'(1) << (DATA_WIDTH - 1);
   assign lim     = neg_ff ? half : (half - QW'(1));
   assign sat     = (q_ff > lim);
   assign mag_lo  = q_ff[DATA_WIDTH-1:0];
   assign val_sgn = neg_ff ? (~mag_lo + DATA_WIDTH'(1)) : mag_lo;

   always_ff @(posedge clock) begin
      if (cmd.load_a) begin
         mcand_ff <= cmd.mop.a_cof ? {{(XW-CW){cof_rd[CW-1]}}, cof_rd}
                                   : {{(XW-DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}}, ram_rdata};
         if (cmd.mop.clear) begin
            acc_ff <= '0;
         end
      end
      if (cmd.load_b) begin
         mplier_ff <= ram_rdata;
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + addend;
         end
         mcand_ff  <= {mcand_ff[XW-2:0], 1'b0};
         mplier_ff <= {mplier_ff[DATA_WIDTH-1], mplier_ff[DATA_WIDTH-1:1]};
      end
      if (cmd.store) begin
         case (cmd.mop.dst)
            DST_COF: cof_ff[cmd.mop.d_idx] <= acc_ff[CW-1:0];
            DST_DET: det_ff <= acc_ff;
            default: ;
         endcase
      end
      // round to nearest: (2|n| + |d|) / (2|d|)
      if (cmd.div_load) begin
         np_ff  <= {num_shift, 1'b0} + QW'(det_mag);
         dp_ff  <= {det_mag[XW-2:0], 1'b0};
         neg_ff <= num_neg ^ det_ff[XW-1];
         rem_ff <= '0;
         q_ff   <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? XW'(trial - {1'b0, dp_ff}) : trial[XW-1:0];
         q_ff   <= {q_ff[QW-2:0], ge};
         np_ff  <= {np_ff[QW-2:0], 1'b0};
      end
      if (cmd.out_load) begin
         val_ff  <= sat ? (neg_ff ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                  : {1'b0, {(DATA_WIDTH-1){1'b1}}})
                        : val_sgn;
         idx_ff  <= cmd.out_index;
         sing_ff <= 1'b0;
         sat_ff  <= sat;
         last_ff <= cmd.out_last;
      end
      if (cmd.sing_load) begin
         val_ff  <= '0;
         idx_ff  <= '0;
         sing_ff <= 1'b1;
         sat_ff  <= 1'b0;
         last_ff <= 1'b1;
      end
   end

   assign rsp_inv_value = val_ff;
   assign rsp_inv_index = idx_ff;
   assign rsp_singular  = sing_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_last      = last_ff;

endmodule

>>> sv/aminv_chk.sv
// Port-level checker for the affine inverse block, bound to the top level.
`include "affine_matrix_inverse_macros.svh"

module aminv_chk (
   input logic               clock,
   input logic               reset,
   input logic               csr_we,
   input logic [31:0]        csr_wdata,
   input logic               req_valid,
   input logic               req_ready,
   input logic signed [31:0] req_coef_value,
   input logic [3:0]         req_coef_index,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_inv_value,
   input logic [3:0]         rsp_inv_index,
   input logic               rsp_singular,
   input logic               rsp_saturated,
   input logic               rsp_last
);

   `AMINV_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result beat dropped")
   `AMINV_ASSERT_IMP(a_busy, rsp_valid, !req_ready, "input taken while a result waits")
   `AMINV_ASSERT_IMP(a_sing_form, rsp_valid && rsp_singular,
      rsp_last && rsp_inv_value == 0 && !rsp_saturated && rsp_inv_index == 0,
      "malformed singular beat")
   `AMINV_ASSERT_IMP(a_last_idx, rsp_valid && !rsp_singular,
      rsp_last == (rsp_inv_index == 4'd11), "last flag off the final entry")
   `AMINV_ASSERT_IMP(a_sat_bound, rsp_valid && rsp_saturated,
      rsp_inv_value == 32'h7fffffff || rsp_inv_value == 32'h80000000,
      "saturated value not at a bound")

endmodule

bind affine_matrix_inverse aminv_chk u_chk (.*);

>>> tb/tb_affine_matrix_inverse.sv
// Testbench for the affine 3x4 matrix inverse: random runs checked against a wide-integer model.
`timescale 1ns / 100ps

module tb_affine_matrix_inverse;
   import aminv_pkg::*;

   localparam int STALL_LIMIT = 30000;
   localparam int HOLD_CYCLES = 400;

   typedef logic signed [255:0] wide_type;

   typedef struct {
      logic signed [31:0] value;
      logic [3:0]         index;
      logic               singular;
      logic               saturated;
      logic               last;
   } inv_beat_type;

   typedef enum int {RUN_WELL, RUN_FULL, RUN_SING, RUN_TINY, RUN_REPEAT} run_kind_type;

   class inverse_scoreboard;
      logic signed [31:0] entries[NCOEF];
      int unsigned        loaded;
      logic [31:0]        threshold;
      inv_beat_type       expected_q[$];
      int                 errors;

      function new();
         loaded    = 0;
         threshold = THRESH_RESET;
         errors    = 0;
         foreach (entries[k]) entries[k] = '0;
      endfunction

      function wide_type at(int r, int c);
         return wide_type'(entries[3 * c + r]);
      endfunction

      // signed quotient rounded to nearest, ties away from zero
      function wide_type round_div(wide_type n, wide_type d);
         logic [255:0] un, ud, q;
         un = n[255] ? -n : n;
         ud = d[255] ? -d : d;
         q  = (2 * un + ud) / (2 * ud);
         return (n[255] != d[255]) ? -wide_type'(q) : wide_type'(q);
      endfunction

      function void push_entry(wide_type q, int k);
         inv_beat_type b;
         wide_type hi, lo;
         hi = wide_type'(32'sh7fffffff);
         lo = -wide_type'(64'sh80000000);
         b.saturated = 1'b1;
         if (q > hi) b.value = 32'sh7fffffff;
         else if (q < lo) b.value = 32'sh80000000;
         else begin
            b.value     = q[31:0];
            b.saturated = 1'b0;
         end
         b.index    = 4'(k);
         b.singular = 1'b0;
         b.last     = (k == NCOEF - 1);
         expected_q.push_back(b);
      endfunction

      function void note_input(logic signed [31:0] v, logic [3:0] idx);
         wide_type adj[3][3];
         wide_type det, num, abs_det;
         inv_beat_type b;
         if (idx >= NCOEF) return;
         entries[idx] = v;
         loaded++;
         if (loaded < NCOEF) return;
         loaded = 0;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
               adj[i][j] = at((j + 1) % 3, (i + 1) % 3) * at((j + 2) % 3, (i + 2) % 3)
                         - at((j + 1) % 3, (i + 2) % 3) * at((j + 2) % 3, (i + 1) % 3);
         det = at(0, 0) * adj[0][0] + at(0, 1) * adj[1][0] + at(0, 2) * adj[2][0];
         abs_det = det[255] ? -det : det;
         if (det == 0 || abs_det < wide_type'({1'b0, threshold})) begin
            b = '{value: '0, index: '0, singular: 1'b1, saturated: 1'b0, last: 1'b1};
            expected_q.push_back(b);
            return;
         end
         for (int k = 0; k < 9; k++)
            push_entry(round_div(adj[k % 3][k / 3] <<< (2 * FRAC_BITS), det), k);
         for (int r = 0; r < 3; r++) begin
            num = adj[r][0] * wide_type'(entries[9]) + adj[r][1] * wide_type'(entries[10])
                + adj[r][2] * wide_type'(entries[11]);
            push_entry(round_div((-num) <<< FRAC_BITS, det), 9 + r);
         end
      endfunction

      function void check(inv_beat_type got);
         inv_beat_type e;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat value=%0d index=%0d", $time, got.value,
                     got.index);
            return;
         end
         e = expected_q.pop_front();
         if (got.value !== e.value) begin
            errors++;
            $display("%0t: inv_value expected %0d actual %0d", $time, e.value, got.value);
         end
         if (got.index !== e.index) begin
            errors++;
            $display("%0t: inv_index expected %0d actual %0d", $time, e.index, got.index);
         end
         if (got.singular !== e.singular) begin
            errors++;
            $display("%0t: singular expected %0b actual %0b", $time, e.singular, got.singular);
         end
         if (got.saturated !== e.saturated) begin
            errors++;
            $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                     got.saturated);
         end
         if (got.last !== e.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, e.last, got.last);
         end
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [31:0]                  csr_wdata;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [DATA_WIDTH-1:0] req_coef_value;
   logic [IDX_W-1:0]             req_coef_index;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [DATA_WIDTH-1:0] rsp_inv_value;
   logic [IDX_W-1:0]             rsp_inv_index;
   logic                         rsp_singular;
   logic                         rsp_saturated;
   logic                         rsp_last;

   inverse_scoreboard sb = new();
   bit  calm;
   int  hold_cnt;
   int  stall_cnt;
   int  items_sent;

   affine_matrix_inverse i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coef_value (req_coef_value),
      .req_coef_index (req_coef_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_inv_value  (rsp_inv_value),
      .rsp_inv_index  (rsp_inv_index),
      .rsp_singular   (rsp_singular),
      .rsp_saturated  (rsp_saturated),
      .rsp_last       (rsp_last)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // result beats: check and watch for a hung block
   always @(posedge clock) begin
      if (reset) begin
         stall_cnt <= 0;
      end else begin
         if (rsp_valid && rsp_ready)
            sb.check('{value: rsp_inv_value, index: rsp_inv_index, singular: rsp_singular,
                       saturated: rsp_saturated, last: rsp_last});
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            stall_cnt <= 0;
         end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end else begin
            stall_cnt <= stall_cnt + 1;
         end
      end
   end

   // receiver side: random stalls, plus a long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 23);
         end
      end
   end

   task automatic send_beat(input logic [31:0] v, input logic [3:0] idx);
      while (!calm && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_coef_value <= v;
      req_coef_index <= idx;
      do @(posedge clock); while (!req_ready);
      sb.note_input(v, idx);
      if (idx < NCOEF) items_sent++;
      @(negedge clock);
   endtask

   task automatic send_noise();
      send_beat($urandom, 4'($urandom_range(12, 15)));
   endtask

   task automatic send_run(input run_kind_type kind);
      logic [31:0] m[NCOEF];
      int order[NCOEF];
      int j, tmp;
      bit dup;
      foreach (order[k]) order[k] = k;
      for (int k = NCOEF - 1; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = order[k];
         order[k] = order[j];
         order[j] = tmp;
      end
      foreach (m[k]) begin
         case (kind)
            RUN_WELL: begin
               if (k % 4 == 0 && k < 9)
                  m[k] = ($urandom_range(1) ? 1 : -1)
                       * int'($urandom_range(32'h8000, 32'h40000));
               else if (k < 9)
                  m[k] = int'($urandom_range(0, 32'h8000)) - 32'h4000;
               else
                  m[k] = $urandom;
            end
            RUN_TINY: m[k] = int'($urandom_range(0, 2047)) - 1024;
            RUN_SING: m[k] = int'($urandom_range(0, 32'h40000)) - 32'h20000;
            default:  m[k] = $urandom;
         endcase
      end
      if (kind == RUN_SING) begin
         // copy the first column into the third, or clear the third column
         dup = $urandom_range(1);
         for (int k = 0; k < 3; k++) m[6 + k] = dup ? m[k] : 32'h0;
      end
      if (kind == RUN_REPEAT) order[$urandom_range(11)] = order[$urandom_range(11)];
      foreach (order[k]) begin
         if ($urandom_range(99) < 8) send_noise();
         send_beat(m[order[k]], 4'(order[k]));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_threshold(input logic [31:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      sb.threshold = v;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [31:0] thr_list[4];
      int goal;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_wdata      = '0;
      req_valid      = 1'b0;
      req_coef_value = '0;
      req_coef_index = '0;
      calm           = 1'b0;
      hold_cnt       = 0;
      items_sent     = 0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // diag(1, -1, 2) with extreme translations, loaded backwards among dropped beats
      for (int k = 0; k < 4; k++) send_beat($urandom, 4'(12 + k));
      for (int k = NCOEF - 1; k >= 0; k--) begin
         case (k)
            0:       send_beat(32'h0001_0000, 4'(k));
            4:       send_beat(32'hffff_0000, 4'(k));
            8:       send_beat(32'h0002_0000, 4'(k));
            9:       send_beat(32'h7fff_ffff, 4'(k));
            10:      send_beat(32'h8000_0000, 4'(k));
            default: send_beat(32'h0, 4'(k));
         endcase
      end
      drain();

      // determinant of one LSB with no threshold: each diagonal linear entry clips
      write_threshold(32'h0);
      send_beat(32'h5, 4'(0));
      for (int k = 0; k < NCOEF - 1; k++)
         send_beat((k % 4 == 0 || k > 8) ? 32'h1 : 32'h0, 4'(k));
      drain();

      thr_list = '{32'h0, 32'hffff_ffff, THRESH_RESET, $urandom};
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thr_list[ph]);
         goal = items_sent + 96;
         calm = (ph == 2);
         while (items_sent < goal) begin
            if (ph == 1 && items_sent + 24 >= goal && items_sent + 12 < goal)
               hold_cnt = HOLD_CYCLES;
            if (ph == 3 && $urandom_range(9) == 0) drain();
            send_run(run_kind_type'($urandom_range(4)));
            if (calm && items_sent + 48 >= goal) calm = 1'b0;
         end
         drain();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/aminv_pkg.sv
sv/aminv_ram.sv
sv/aminv_ctrl.sv
sv/aminv_dp.sv
sv/affine_matrix_inverse.sv
sv/aminv_chk.sv
tb/tb_affine_matrix_inverse.sv
